// ===== hw/rtl/etpm_pkg.sv =====
// etpm_pkg: shared types and constants of the ESC throttle to PWM mapper.
// No dependencies; used by every module of the block.

package etpm_pkg;

   // Throttle limits for the command field and for the applied field
   localparam logic signed [15:0] REQ_PCT_MIN = -16'sd100;
   localparam logic signed [15:0] REQ_PCT_MAX = 16'sd100;
   localparam logic signed [7:0]  PCT_MIN     = -8'sd100;
   localparam logic signed [7:0]  PCT_MAX     = 8'sd100;
   localparam logic signed [7:0]  PCT_OFFSET  = 8'sd100;

   localparam logic [31:0] US_PER_S = 32'd1000000;

   // floor(x/100) == (x * RECIP_100) >> RECIP_SHIFT for every x below 2^23
   localparam logic [23:0] RECIP_100   = 24'd10737419;
   localparam int          RECIP_SHIFT = 30;

   // Serial divider widths: dividend up to pulse*max_duty, divisor up to the period
   localparam int DIV_NUM_W = 32;
   localparam int DIV_DEN_W = 20;
   localparam int DIV_CNT_W = $clog2(DIV_NUM_W);

   localparam logic [4:0] MAX_RES_BITS = 5'd16;

   // Register map, index = byte address / 4
   localparam logic [2:0] REG_REVERSE_PULSE = 3'd0;
   localparam logic [2:0] REG_NEUTRAL_PULSE = 3'd1;
   localparam logic [2:0] REG_FORWARD_PULSE = 3'd2;
   localparam logic [2:0] REG_PWM_FREQ      = 3'd3;
   localparam logic [2:0] REG_DUTY_RES      = 3'd4;
   localparam logic [2:0] REG_NEUTRAL_HOLD  = 3'd5;

   localparam logic [15:0] RST_REVERSE_PULSE = 16'd1000;
   localparam logic [15:0] RST_NEUTRAL_PULSE = 16'd1500;
   localparam logic [15:0] RST_FORWARD_PULSE = 16'd2000;
   localparam logic [15:0] RST_PWM_FREQ      = 16'd50;
   localparam logic [4:0]  RST_DUTY_RES      = 5'd16;
   localparam logic [15:0] RST_NEUTRAL_HOLD  = 16'd250;

   typedef struct packed {
      logic [15:0] reverse_pulse_us;
      logic [15:0] neutral_pulse_us;
      logic [15:0] forward_pulse_us;
      logic [15:0] pwm_frequency_hz;
      logic [4:0]  duty_resolution_bits;
      logic [15:0] neutral_hold_ms;
   } etpm_cfg_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EVAL,
      ST_SPAN_MUL,
      ST_SPAN_DIV,
      ST_PULSE,
      ST_PREP,
      ST_PERIOD_WAIT,
      ST_DUTY_MUL,
      ST_DUTY_START,
      ST_DUTY_WAIT,
      ST_EMIT
   } etpm_state_type;

   typedef struct packed {
      logic capture;
      logic apply_zero;
      logic apply_reverse;
      logic apply_run;
      logic span_mul;
      logic span_div;
      logic pulse_calc;
      logic period_start;
      logic period_load;
      logic duty_mul;
      logic duty_start;
      logic duty_load;
      logic load_out;
   } etpm_cmd_type;

   typedef struct packed {
      logic is_zero;
      logic hold_block;
      logic reversal;
      logic div_done;
   } etpm_status_type;

endpackage

// ===== hw/rtl/etpm_divider.sv =====
// etpm_divider: unsigned restoring divider, one quotient bit per cycle.
// Depends on etpm_pkg for its widths.

module etpm_divider (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [etpm_pkg::DIV_NUM_W-1:0] dividend,
   input  logic [etpm_pkg::DIV_DEN_W-1:0] divisor,
   output logic [etpm_pkg::DIV_NUM_W-1:0] quotient,
   output logic                           done
);

   localparam logic [etpm_pkg::DIV_CNT_W-1:0] LAST_STEP =
      etpm_pkg::DIV_CNT_W'(etpm_pkg::DIV_NUM_W - 1);

   logic                           busy_ff;
   logic                           done_ff;
   logic [etpm_pkg::DIV_CNT_W-1:0] count_ff;
   logic [etpm_pkg::DIV_DEN_W-1:0] rem_ff;
   logic [etpm_pkg::DIV_NUM_W-1:0] quo_ff;
   logic [etpm_pkg::DIV_DEN_W-1:0] dvs_ff;

   logic [etpm_pkg::DIV_DEN_W:0] shifted;
   logic [etpm_pkg::DIV_DEN_W:0] trial;
   logic                         fits;

   assign shifted = {rem_ff, quo_ff[etpm_pkg::DIV_NUM_W-1]};
   assign trial   = shifted - {1'b0, dvs_ff};
   assign fits    = (shifted >= {1'b0, dvs_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= busy_ff && (count_ff == LAST_STEP);
         if (start) begin
            busy_ff  <= 1'b1;
            count_ff <= '0;
         end else if (busy_ff) begin
            count_ff <= count_ff + 1'b1;
            if (count_ff == LAST_STEP) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= fits ? trial[etpm_pkg::DIV_DEN_W-1:0] : shifted[etpm_pkg::DIV_DEN_W-1:0];
         quo_ff <= {quo_ff[etpm_pkg::DIV_NUM_W-2:0], fits};
      end
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule

// ===== hw/rtl/etpm_datapath.sv =====
// etpm_datapath: throttle state, span mapping, duty computation and result registers.
// Depends on etpm_pkg and etpm_divider; driven by etpm_ctrl commands.

module etpm_datapath (
   input  logic                      clock,
   input  logic                      reset,
   input  etpm_pkg::etpm_cfg_type    cfg,
   input  etpm_pkg::etpm_cmd_type    cmd,
   output etpm_pkg::etpm_status_type status,
   input  logic signed [15:0]        req_requested_percent,
   input  logic [31:0]               req_now_ms,
   output logic [15:0]               rsp_duty_value,
   output logic [15:0]               rsp_pulse_width_us,
   output logic signed [7:0]         rsp_applied_percent,
   output logic                      rsp_forced_neutral
);

   // request and throttle state
   logic signed [7:0] pct_ff;
   logic [31:0]       now_ff;
   logic signed [7:0] applied_ff;
   logic [31:0]       hold_end_ff;
   logic              hold_valid_ff;

   // per-request working registers
   logic [15:0]       lo_ff;
   logic              span_neg_ff;
   logic [22:0]       span_prod_ff;
   logic [15:0]       quot100_ff;
   logic [15:0]       pulse_ff;
   logic signed [7:0] res_pct_ff;
   logic              res_forced_ff;
   logic [etpm_pkg::DIV_DEN_W-1:0] period_ff;
   logic [31:0]       duty_prod_ff;
   logic [15:0]       duty_ff;

   // result registers
   logic [15:0]       out_duty_ff;
   logic [15:0]       out_pulse_ff;
   logic signed [7:0] out_pct_ff;
   logic              out_forced_ff;

   logic signed [7:0] pct_clamped;
   logic [31:0]       hold_diff;
   logic              neg;
   logic [15:0]       lo_sel;
   logic [15:0]       hi_sel;
   logic [7:0]        p_sel;
   logic [16:0]       span_diff;
   logic [16:0]       span_mag;
   logic [46:0]       recip_prod;
   logic [4:0]        res_eff;
   logic [16:0]       max_duty_wide;
   logic [15:0]       max_duty;

   logic                           div_start;
   logic [etpm_pkg::DIV_NUM_W-1:0] div_dividend;
   logic [etpm_pkg::DIV_DEN_W-1:0] div_divisor;
   logic [etpm_pkg::DIV_NUM_W-1:0] div_quotient;
   logic                           div_done;

   always_comb begin
      priority if (req_requested_percent < etpm_pkg::REQ_PCT_MIN) begin
         pct_clamped = etpm_pkg::PCT_MIN;
      end else if (req_requested_percent > etpm_pkg::REQ_PCT_MAX) begin
         pct_clamped = etpm_pkg::PCT_MAX;
      end else begin
         pct_clamped = req_requested_percent[7:0];
      end
   end

   assign hold_diff = now_ff - hold_end_ff;

   assign status.is_zero    = (pct_ff == 8'sd0);
   assign status.hold_block = hold_valid_ff && hold_diff[31];
   assign status.reversal   = (applied_ff != 8'sd0) && (applied_ff[7] != pct_ff[7]);
   assign status.div_done   = div_done;

   // reverse span runs reverse..neutral with p = pct + 100, forward neutral..forward
   assign neg       = pct_ff[7];
   assign lo_sel    = neg ? cfg.reverse_pulse_us : cfg.neutral_pulse_us;
   assign hi_sel    = neg ? cfg.neutral_pulse_us : cfg.forward_pulse_us;
   assign p_sel     = neg ? 8'(pct_ff + etpm_pkg::PCT_OFFSET) : 8'(pct_ff);
   assign span_diff = {1'b0, hi_sel} - {1'b0, lo_sel};
   assign span_mag  = span_diff[16] ? (17'd0 - span_diff) : span_diff;

   assign recip_prod = 47'(span_prod_ff) * 47'(etpm_pkg::RECIP_100);

   assign res_eff       = (cfg.duty_resolution_bits > etpm_pkg::MAX_RES_BITS) ?
                          etpm_pkg::MAX_RES_BITS : cfg.duty_resolution_bits;
   assign max_duty_wide = (17'd1 << res_eff) - 17'd1;
   assign max_duty      = max_duty_wide[15:0];

   assign div_start    = cmd.period_start || cmd.duty_start;
   assign div_dividend = cmd.duty_start ? duty_prod_ff : etpm_pkg::US_PER_S;
   assign div_divisor  = cmd.duty_start ? period_ff :
                         etpm_pkg::DIV_DEN_W'(cfg.pwm_frequency_hz);

   etpm_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .quotient (div_quotient),
      .done     (div_done)
   );

   // throttle state
   always_ff @(posedge clock) begin
      if (reset) begin
         applied_ff    <= 8'sd0;
         hold_end_ff   <= '0;
         hold_valid_ff <= 1'b0;
      end else if (cmd.apply_zero) begin
         applied_ff    <= 8'sd0;
         hold_end_ff   <= '0;
         hold_valid_ff <= 1'b0;
      end else if (cmd.apply_reverse) begin
         applied_ff    <= 8'sd0;
         hold_end_ff   <= now_ff + 32'(cfg.neutral_hold_ms);
         hold_valid_ff <= 1'b1;
      end else if (cmd.apply_run) begin
         applied_ff    <= pct_ff;
         hold_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         pct_ff <= pct_clamped;
         now_ff <= req_now_ms;
      end
      if (cmd.apply_zero || cmd.apply_reverse) begin
         pulse_ff      <= cfg.neutral_pulse_us;
         res_pct_ff    <= 8'sd0;
         res_forced_ff <= cmd.apply_reverse;
      end else if (cmd.pulse_calc) begin
         pulse_ff <= span_neg_ff ? (lo_ff - quot100_ff) : (lo_ff + quot100_ff);
      end
      if (cmd.apply_run) begin
         res_pct_ff    <= pct_ff;
         res_forced_ff <= 1'b0;
      end
      if (cmd.span_mul) begin
         lo_ff        <= lo_sel;
         span_neg_ff  <= span_diff[16];
         span_prod_ff <= 23'(span_mag[15:0] * p_sel[6:0]);
      end
      if (cmd.span_div) begin
         quot100_ff <= recip_prod[etpm_pkg::RECIP_SHIFT+15:etpm_pkg::RECIP_SHIFT];
      end
      if (cmd.period_load) begin
         period_ff <= div_quotient[etpm_pkg::DIV_DEN_W-1:0];
      end
      if (cmd.duty_mul) begin
         duty_prod_ff <= 32'(pulse_ff) * 32'(max_duty);
      end
      if (cmd.duty_load) begin
         // no frame period when the frequency is zero: saturate
         if ((cfg.pwm_frequency_hz == 16'd0) || (div_quotient > 32'(max_duty))) begin
            duty_ff <= max_duty;
         end else begin
            duty_ff <= div_quotient[15:0];
         end
      end
      if (cmd.load_out) begin
         out_duty_ff   <= duty_ff;
         out_pulse_ff  <= pulse_ff;
         out_pct_ff    <= res_pct_ff;
         out_forced_ff <= res_forced_ff;
      end
   end

   assign rsp_duty_value      = out_duty_ff;
   assign rsp_pulse_width_us  = out_pulse_ff;
   assign rsp_applied_percent = out_pct_ff;
   assign rsp_forced_neutral  = out_forced_ff;

endmodule

// ===== hw/rtl/etpm_ctrl.sv =====
// etpm_ctrl: sequencer for one throttle request and the response handshake.
// Depends on etpm_pkg; commands etpm_datapath.

module etpm_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  logic                      freq_written,
   input  etpm_pkg::etpm_status_type status,
   output etpm_pkg::etpm_cmd_type    cmd
);

   etpm_pkg::etpm_state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic period_stale_ff, period_stale_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= etpm_pkg::ST_IDLE;
         rsp_valid_ff    <= 1'b0;
         period_stale_ff <= 1'b1;
      end else begin
         state_ff        <= state_in;
         rsp_valid_ff    <= rsp_valid_in;
         period_stale_ff <= period_stale_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;

      unique case (state_ff)
         etpm_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = etpm_pkg::ST_EVAL;
            end
         end
         etpm_pkg::ST_EVAL: begin
            priority if (status.is_zero) begin
               cmd.apply_zero = 1'b1;
               state_in       = etpm_pkg::ST_PREP;
            end else if (status.hold_block) begin
               state_in = etpm_pkg::ST_IDLE;   // ignored during hold, no response
            end else if (status.reversal) begin
               cmd.apply_reverse = 1'b1;
               state_in          = etpm_pkg::ST_PREP;
            end else begin
               cmd.apply_run = 1'b1;
               state_in      = etpm_pkg::ST_SPAN_MUL;
            end
         end
         etpm_pkg::ST_SPAN_MUL: begin
            cmd.span_mul = 1'b1;
            state_in     = etpm_pkg::ST_SPAN_DIV;
         end
         etpm_pkg::ST_SPAN_DIV: begin
            cmd.span_div = 1'b1;
            state_in     = etpm_pkg::ST_PULSE;
         end
         etpm_pkg::ST_PULSE: begin
            cmd.pulse_calc = 1'b1;
            state_in       = etpm_pkg::ST_PREP;
         end
         etpm_pkg::ST_PREP: begin
            if (period_stale_ff) begin
               cmd.period_start = 1'b1;
               state_in         = etpm_pkg::ST_PERIOD_WAIT;
            end else begin
               state_in = etpm_pkg::ST_DUTY_MUL;
            end
         end
         etpm_pkg::ST_PERIOD_WAIT: begin
            if (status.div_done) begin
               cmd.period_load = 1'b1;
               state_in        = etpm_pkg::ST_DUTY_MUL;
            end
         end
         etpm_pkg::ST_DUTY_MUL: begin
            cmd.duty_mul = 1'b1;
            state_in     = etpm_pkg::ST_DUTY_START;
         end
         etpm_pkg::ST_DUTY_START: begin
            cmd.duty_start = 1'b1;
            state_in       = etpm_pkg::ST_DUTY_WAIT;
         end
         etpm_pkg::ST_DUTY_WAIT: begin
            if (status.div_done) begin
               cmd.duty_load = 1'b1;
               state_in      = etpm_pkg::ST_EMIT;
            end
         end
         etpm_pkg::ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_out = 1'b1;
               state_in     = etpm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = etpm_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // period is recomputed after reset and after every frequency write
   always_comb begin
      if (freq_written) begin
         period_stale_in = 1'b1;
      end else if (cmd.period_load) begin
         period_stale_in = 1'b0;
      end else begin
         period_stale_in = period_stale_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== hw/rtl/esc_throttle_pwm_mapper.sv =====
// esc_throttle_pwm_mapper: top level, register file and controller/datapath hookup.
// Depends on etpm_pkg, etpm_ctrl, etpm_datapath (which holds etpm_divider).
// Usage
//  - req_*: throttle percent (signed, clamped to -100..100) and the free-running
//    millisecond time. Zero gives the neutral pulse and ends any hold; a direction
//    reversal from a nonzero throttle gives neutral with rsp_forced_neutral set and
//    starts a neutral hold. A nonzero request during the hold gets no response.
//  - rsp_*: duty compare value, pulse width, applied percent, forced-neutral flag,
//    held in an output register.
//  - csr_*: APB-style, registers at byte address 4*index, written at the access
//    cycle, pready tied high. Write only while idle.
// Timing
//  - One request at a time: a running command passes span multiply, span divide and
//    pulse, then, like a neutral one, the 32-step serial divider for the duty.
//    The next request is taken in the cycle after the result is loaded.
//  - After reset and after each pwm_frequency_hz write, the next answered request
//    also runs the 1000000/frequency division first.
//  - Receiver stall: the next request is still taken and finished; its result waits
//    for the output register, with req_ready low meanwhile.
// Reset (synchronous): registers to defaults, throttle zero with no hold, no response.

module esc_throttle_pwm_mapper (
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [15:0] req_requested_percent,
   input  logic [31:0]        req_now_ms,
   // response channel
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [15:0]        rsp_duty_value,
   output logic [15:0]        rsp_pulse_width_us,
   output logic signed [7:0]  rsp_applied_percent,
   output logic               rsp_forced_neutral,
   // CSR port
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [4:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);

   etpm_pkg::etpm_cfg_type    cfg_ff;
   etpm_pkg::etpm_cmd_type    cmd;
   etpm_pkg::etpm_status_type status;

   logic       csr_write;
   logic [2:0] csr_index;
   logic       freq_written;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[4:2];   // byte offset bits ignored

   assign freq_written = csr_write && (csr_index == etpm_pkg::REG_PWM_FREQ);

   // Register file; writes past the last register are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.reverse_pulse_us     <= etpm_pkg::RST_REVERSE_PULSE;
         cfg_ff.neutral_pulse_us     <= etpm_pkg::RST_NEUTRAL_PULSE;
         cfg_ff.forward_pulse_us     <= etpm_pkg::RST_FORWARD_PULSE;
         cfg_ff.pwm_frequency_hz     <= etpm_pkg::RST_PWM_FREQ;
         cfg_ff.duty_resolution_bits <= etpm_pkg::RST_DUTY_RES;
         cfg_ff.neutral_hold_ms      <= etpm_pkg::RST_NEUTRAL_HOLD;
      end else if (csr_write) begin
         unique case (csr_index)
            etpm_pkg::REG_REVERSE_PULSE: cfg_ff.reverse_pulse_us     <= csr_pwdata[15:0];
            etpm_pkg::REG_NEUTRAL_PULSE: cfg_ff.neutral_pulse_us     <= csr_pwdata[15:0];
            etpm_pkg::REG_FORWARD_PULSE: cfg_ff.forward_pulse_us     <= csr_pwdata[15:0];
            etpm_pkg::REG_PWM_FREQ:      cfg_ff.pwm_frequency_hz     <= csr_pwdata[15:0];
            etpm_pkg::REG_DUTY_RES:      cfg_ff.duty_resolution_bits <= csr_pwdata[4:0];
            etpm_pkg::REG_NEUTRAL_HOLD:  cfg_ff.neutral_hold_ms      <= csr_pwdata[15:0];
            default: begin
            end
         endcase
      end
   end

   // Read-back, zero-extended
   always_comb begin
      unique case (csr_index)
         etpm_pkg::REG_REVERSE_PULSE: csr_prdata = 32'(cfg_ff.reverse_pulse_us);
         etpm_pkg::REG_NEUTRAL_PULSE: csr_prdata = 32'(cfg_ff.neutral_pulse_us);
         etpm_pkg::REG_FORWARD_PULSE: csr_prdata = 32'(cfg_ff.forward_pulse_us);
         etpm_pkg::REG_PWM_FREQ:      csr_prdata = 32'(cfg_ff.pwm_frequency_hz);
         etpm_pkg::REG_DUTY_RES:      csr_prdata = 32'(cfg_ff.duty_resolution_bits);
         etpm_pkg::REG_NEUTRAL_HOLD:  csr_prdata = 32'(cfg_ff.neutral_hold_ms);
         default:                     csr_prdata = 32'd0;
      endcase
   end

   etpm_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .freq_written (freq_written),
      .status       (status),
      .cmd          (cmd)
   );

   etpm_datapath u_datapath (
      .clock                 (clock),
      .reset                 (reset),
      .cfg                   (cfg_ff),
      .cmd                   (cmd),
      .status                (status),
      .req_requested_percent (req_requested_percent),
      .req_now_ms            (req_now_ms),
      .rsp_duty_value        (rsp_duty_value),
      .rsp_pulse_width_us    (rsp_pulse_width_us),
      .rsp_applied_percent   (rsp_applied_percent),
      .rsp_forced_neutral    (rsp_forced_neutral)
   );

endmodule

// ===== hw/rtl/etpm_checker.sv =====
// etpm_checker: port-level assertions for esc_throttle_pwm_mapper, with its bind.
// Depends on etpm_pkg for the percent limits.

module etpm_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [15:0]       rsp_duty_value,
   input logic [15:0]       rsp_pulse_width_us,
   input logic signed [7:0] rsp_applied_percent,
   input logic              rsp_forced_neutral
);

   // a stalled response keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_duty_value) &&
         $stable(rsp_pulse_width_us) && $stable(rsp_applied_percent) &&
         $stable(rsp_forced_neutral))
      else $error("stalled response changed");

   // one request in flight: no accept right after an accept
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   // a forced neutral always reports zero throttle
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_forced_neutral |-> rsp_applied_percent == 8'sd0)
      else $error("forced neutral with nonzero percent");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_applied_percent >= etpm_pkg::PCT_MIN) &&
         (rsp_applied_percent <= etpm_pkg::PCT_MAX))
      else $error("applied percent out of range");

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind esc_throttle_pwm_mapper etpm_checker u_etpm_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_valid),
   .req_ready           (req_ready),
   .rsp_valid           (rsp_valid),
   .rsp_ready           (rsp_ready),
   .rsp_duty_value      (rsp_duty_value),
   .rsp_pulse_width_us  (rsp_pulse_width_us),
   .rsp_applied_percent (rsp_applied_percent),
   .rsp_forced_neutral  (rsp_forced_neutral)
);

// ===== verif/tb_esc_throttle_pwm_mapper.sv =====
// tb_esc_throttle_pwm_mapper: self-checking testbench for the ESC throttle to PWM mapper.
// Depends on etpm_pkg and esc_throttle_pwm_mapper; a scoreboard class tracks throttle,
// hold and register state and checks each response against its own prediction.
`timescale 1ns / 100ps

module tb_esc_throttle_pwm_mapper;

   // Cycles to let an in-flight request finish when it may produce no response:
   // enough for the work of one request plus a period recompute, with margin.
   localparam int SETTLE_CYCLES = 120;
   // Long receiver hold-off, long enough that the block fills and stalls req_ready
   localparam int LONG_STALL    = 300;
   localparam int PHASE_ITEMS   = 105;
   localparam int RUN_LIMIT_NS  = 1500000;

   // One response of the block, field by field
   typedef struct packed {
      logic [15:0]       duty;
      logic [15:0]       pulse_us;
      logic signed [7:0] pct;
      logic              forced;
   } esc_output_type;

   // Scoreboard: mirror of the registers and of the throttle/hold state, plus the
   // queue of responses still owed by the block.
   class throttle_duty_tracker_type;
      logic [15:0]       reg_reverse, reg_neutral, reg_forward, reg_freq, reg_hold;
      logic [4:0]        reg_res;
      logic signed [7:0] cur_throttle;
      logic [31:0]       hold_end;
      bit                hold_live;
      esc_output_type    pending_outputs[$];
      int                mismatches, checked, accepted, dropped, reversals, settings;

      function new();
         reg_reverse  = etpm_pkg::RST_REVERSE_PULSE;
         reg_neutral  = etpm_pkg::RST_NEUTRAL_PULSE;
         reg_forward  = etpm_pkg::RST_FORWARD_PULSE;
         reg_freq     = etpm_pkg::RST_PWM_FREQ;
         reg_res      = etpm_pkg::RST_DUTY_RES;
         reg_hold     = etpm_pkg::RST_NEUTRAL_HOLD;
         cur_throttle = '0;
         hold_end     = '0;
         hold_live    = 1'b0;
         settings     = 1;
      endfunction

      function void write_reg(logic [2:0] idx, logic [31:0] value);
         case (idx)
            etpm_pkg::REG_REVERSE_PULSE: reg_reverse = value[15:0];
            etpm_pkg::REG_NEUTRAL_PULSE: reg_neutral = value[15:0];
            etpm_pkg::REG_FORWARD_PULSE: reg_forward = value[15:0];
            etpm_pkg::REG_PWM_FREQ:      reg_freq    = value[15:0];
            etpm_pkg::REG_DUTY_RES:      reg_res     = value[4:0];
            etpm_pkg::REG_NEUTRAL_HOLD:  reg_hold    = value[15:0];
            default: ;
         endcase
      endfunction

      // duty = pulse * (2^res - 1) / (1000000 / freq), saturated at 2^res - 1
      function logic [15:0] duty_for(logic [15:0] pulse);
         int unsigned       bits;
         longint unsigned   top, period, q, p;
         bits = (reg_res > etpm_pkg::MAX_RES_BITS) ? 16 : 32'(reg_res);
         top  = (64'd1 << bits) - 64'd1;
         if (reg_freq == 0) return top[15:0];
         period = 64'(etpm_pkg::US_PER_S / 32'(reg_freq));
         if (period == 0) return top[15:0];
         p = 64'(pulse);
         q = (p * top) / period;
         if (q > top) q = top;
         return q[15:0];
      endfunction

      function void push_output(logic [15:0] pulse, logic signed [7:0] pct, logic forced);
         esc_output_type r;
         r.duty     = duty_for(pulse);
         r.pulse_us = pulse;
         r.pct      = pct;
         r.forced   = forced;
         pending_outputs.push_back(r);
      endfunction

      // Predict the outcome of one accepted request
      function void note_request(logic signed [15:0] pct_in, logic [31:0] now);
         int          pct, lo, hi, span;
         logic [31:0] diff, pulse;
         accepted++;
         pct = int'(pct_in);
         if (pct < int'(etpm_pkg::PCT_MIN)) pct = int'(etpm_pkg::PCT_MIN);
         if (pct > int'(etpm_pkg::PCT_MAX)) pct = int'(etpm_pkg::PCT_MAX);

         // zero command: neutral, ends any hold
         if (pct == 0) begin
            cur_throttle = '0;
            hold_end     = '0;
            hold_live    = 1'b0;
            push_output(reg_neutral, 8'sd0, 1'b0);
            return;
         end

         // hold active while (now - hold_end) is negative, wrapped
         if (hold_live) begin
            diff = now - hold_end;
            if (diff[31]) begin
               dropped++;
               return;
            end
            hold_live = 1'b0;
         end

         // direction reversal from a nonzero throttle forces neutral
         if (cur_throttle != 0 && ((cur_throttle < 0) != (pct < 0))) begin
            cur_throttle = '0;
            hold_end     = now + 32'(reg_hold);
            hold_live    = 1'b1;
            reversals++;
            push_output(reg_neutral, 8'sd0, 1'b1);
            return;
         end

         cur_throttle = pct[7:0];
         if (pct < 0) begin
            lo   = int'(reg_reverse);
            hi   = int'(reg_neutral);
            span = ((pct + 100) * (hi - lo)) / 100;
         end else begin
            lo   = int'(reg_neutral);
            hi   = int'(reg_forward);
            span = (pct * (hi - lo)) / 100;
         end
         pulse = 32'(lo + span);
         push_output(pulse[15:0], pct[7:0], 1'b0);
      endfunction

      function void check_result(logic [15:0] duty, logic [15:0] pulse,
                                 logic signed [7:0] pct, logic forced);
         esc_output_type want;
         checked++;
         if (pending_outputs.size() == 0) begin
            $display("%0t: response with nothing pending: duty %0d pulse %0d pct %0d forced %0b",
                     $time, duty, pulse, pct, forced);
            mismatches++;
            return;
         end
         want = pending_outputs.pop_front();
         if (duty !== want.duty) begin
            $display("%0t: duty_value expected %0d, got %0d", $time, want.duty, duty);
            mismatches++;
         end
         if (pulse !== want.pulse_us) begin
            $display("%0t: pulse_width_us expected %0d, got %0d", $time, want.pulse_us, pulse);
            mismatches++;
         end
         if (pct !== want.pct) begin
            $display("%0t: applied_percent expected %0d, got %0d", $time, want.pct, pct);
            mismatches++;
         end
         if (forced !== want.forced) begin
            $display("%0t: forced_neutral expected %0b, got %0b", $time, want.forced, forced);
            mismatches++;
         end
      endfunction
   endclass

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic signed [15:0] req_requested_percent;
   logic [31:0]        req_now_ms;
   logic               rsp_valid;
   logic               rsp_ready;
   logic [15:0]        rsp_duty_value;
   logic [15:0]        rsp_pulse_width_us;
   logic signed [7:0]  rsp_applied_percent;
   logic               rsp_forced_neutral;
   logic               csr_psel;
   logic               csr_penable;
   logic               csr_pwrite;
   logic [4:0]         csr_paddr;
   logic [31:0]        csr_pwdata;
   logic [31:0]        csr_prdata;
   logic               csr_pready;

   throttle_duty_tracker_type tracker = new();

   // Receiver pacing state
   int stall_request = 0;   // set by the stimulus, taken over by the receiver
   int stall_left    = 0;
   int ready_pct     = 100;
   int window_left   = 0;

   // Stimulus state: millisecond time base and current throttle direction
   logic [31:0] ms_now;
   int          heading;
   int          phase_hold;

   esc_throttle_pwm_mapper i_dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_requested_percent (req_requested_percent),
      .req_now_ms            (req_now_ms),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_duty_value        (rsp_duty_value),
      .rsp_pulse_width_us    (rsp_pulse_width_us),
      .rsp_applied_percent   (rsp_applied_percent),
      .rsp_forced_neutral    (rsp_forced_neutral),
      .csr_psel              (csr_psel),
      .csr_penable           (csr_penable),
      .csr_pwrite            (csr_pwrite),
      .csr_paddr             (csr_paddr),
      .csr_pwdata            (csr_pwdata),
      .csr_prdata            (csr_prdata),
      .csr_pready            (csr_pready)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   // Watchdog: generous bound over the slowest legal run
   initial begin
      #RUN_LIMIT_NS;
      $display("%0t: timeout, %0d responses still pending", $time,
               tracker.pending_outputs.size());
      $display("esc_throttle_pwm_mapper: mismatch");
      $finish;
   end

   // Response side. Outputs are sampled at the edge before any update lands, so the
   // handshake seen here is the one the block saw. rsp_ready follows a pattern that
   // is redrawn for each window (always ready down to mostly stalled); a long hold-off
   // asked by the stimulus takes priority and is counted down here.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         tracker.check_result(rsp_duty_value, rsp_pulse_width_us,
                              rsp_applied_percent, rsp_forced_neutral);
      if (stall_request > 0) begin
         stall_left    = stall_request;
         stall_request = 0;
      end
      if (window_left == 0) begin
         window_left = 50;
         case ($urandom_range(0, 4))
            0, 1: ready_pct = 100;
            2:    ready_pct = 70;
            3:    ready_pct = 35;
            default: ready_pct = 10;
         endcase
      end
      window_left--;
      if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(1, 100) <= ready_pct);
      end
   end

   // Offer one request and hold it until accepted; valid stays high on return so a
   // following request can go out back to back.
   task automatic send_request(logic signed [15:0] pct, logic [31:0] now);
      req_valid             <= 1'b1;
      req_requested_percent <= pct;
      req_now_ms            <= now;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      tracker.note_request(pct, now);
   endtask

   // APB write: setup then access; the register takes the value at the access edge.
   // psel/penable are left for the caller to drop once, after the last write.
   task automatic csr_write(logic [2:0] idx, logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      tracker.write_reg(idx, value);
   endtask

   // Idle the request side, wait for every owed response, then let any request that
   // was swallowed by a hold finish inside the block.
   task automatic drain_block();
      req_valid <= 1'b0;
      while (tracker.pending_outputs.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic apply_config(logic [15:0] rev, logic [15:0] neu, logic [15:0] fwd,
                               logic [15:0] freq, logic [4:0] res, logic [15:0] hold);
      drain_block();
      csr_write(etpm_pkg::REG_REVERSE_PULSE, {16'd0, rev});
      csr_write(etpm_pkg::REG_NEUTRAL_PULSE, {16'd0, neu});
      csr_write(etpm_pkg::REG_FORWARD_PULSE, {16'd0, fwd});
      csr_write(etpm_pkg::REG_PWM_FREQ,      {16'd0, freq});
      csr_write(etpm_pkg::REG_DUTY_RES,      {27'd0, res});
      csr_write(etpm_pkg::REG_NEUTRAL_HOLD,  {16'd0, hold});
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      phase_hold = int'(hold);
      tracker.settings++;
   endtask

   // Directed opening at reset settings (hold 250 ms): clamping, zero, reversal,
   // requests dropped inside a hold, hold expiry on the exact end time, and a hold
   // whose end time wraps past 2^32.
   task automatic run_directed();
      send_request(16'sd0,      32'd0);
      send_request(16'sd100,    32'd10);
      send_request(-16'sd100,   32'd20);     // reversal, hold until 270
      send_request(-16'sd100,   32'd30);     // inside hold: dropped
      send_request(-16'sd50,    32'd269);    // last ms of hold: dropped
      send_request(-16'sd100,   32'd270);    // hold over, full reverse
      send_request(-16'sd1,     32'd271);
      send_request(16'sd1,      32'd272);    // reversal by the smallest step
      send_request(16'sd0,      32'd300);    // zero clears the hold
      send_request(16'sd1,      32'd301);
      send_request(16'sd32767,  32'd302);    // clamps to +100
      send_request(-16'sd32768, 32'd303);    // clamps to -100, reversal
      send_request(16'sd32767,  32'd400);    // dropped
      send_request(-16'sd101,   32'd553);    // hold over, clamps to -100
      send_request(16'sd101,    32'd554);    // reversal, hold until 804
      send_request(16'sd50,     32'h7FFF_FFFF);
      send_request(-16'sd50,    32'hFFFF_FFF0); // reversal, hold end wraps to 0xEA
      send_request(-16'sd50,    32'h0000_0010); // still held across the wrap
      send_request(-16'sd99,    32'h0000_00EA);
      send_request(16'sd99,     32'h0000_00EB); // reversal
      send_request(16'sd0,      32'hFFFF_FFFF);
      send_request(16'sd100,    32'h8000_0000);
   endtask

   // Random part: mostly coherent throttle traffic on an advancing clock with frequent
   // reversals, plus zeros, out-of-range commands, raw noise, time jumps and clock
   // steps backward. Sender works in bursts; partway in, the receiver holds off.
   task automatic run_random(int count);
      int sent, burst_left, gap, roll, mag;
      logic signed [15:0] pct;
      burst_left = $urandom_range(1, 16);
      for (sent = 0; sent < count; sent++) begin
         if (sent == count / 4) stall_request = LONG_STALL;

         roll = $urandom_range(0, 99);
         if (roll < 8) begin
            pct = 16'sd0;
         end else if (roll < 14) begin
            pct = 16'($urandom());
         end else begin
            if ($urandom_range(0, 99) < 35) heading = -heading;
            case ($urandom_range(0, 9))
               0:       mag = 100;
               1:       mag = $urandom_range(101, 400);
               default: mag = $urandom_range(1, 100);
            endcase
            pct = 16'(heading * mag);
         end

         roll = $urandom_range(0, 99);
         if (roll < 5)
            ms_now = $urandom();
         else if (roll < 9)
            ms_now = ms_now - $urandom_range(0, 50);
         else
            ms_now = ms_now + $urandom_range(0, phase_hold / 3 + 4);

         send_request(pct, ms_now);

         burst_left--;
         if (burst_left == 0 && sent != count - 1) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
               req_valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
      end
   endtask

   initial begin
      reset                 = 1'b1;
      req_valid             = 1'b0;
      req_requested_percent = '0;
      req_now_ms            = '0;
      rsp_ready             = 1'b0;
      csr_psel              = 1'b0;
      csr_penable           = 1'b0;
      csr_pwrite            = 1'b0;
      csr_paddr             = '0;
      csr_pwdata            = '0;
      ms_now                = 32'd1000;
      heading               = 1;
      phase_hold            = int'(etpm_pkg::RST_NEUTRAL_HOLD);

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      run_directed();

      // Settings sweep: extremes first (slowest/fastest frame, widest/narrowest duty,
      // inverted spans, no hold and longest hold), then random, then the defaults
      // again with the clock just short of its wrap.
      apply_config(16'd0, 16'd32768, 16'd65535, 16'd1, 5'd16, 16'd0);
      run_random(PHASE_ITEMS);
      apply_config(16'd65535, 16'd0, 16'd65535, 16'd40000, 5'd1, 16'd65535);
      run_random(PHASE_ITEMS);
      apply_config(16'd2000, 16'd1500, 16'd1000, 16'd400, 5'd8, 16'd20);
      run_random(PHASE_ITEMS);
      apply_config(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                   16'($urandom_range(0, 65535)), 16'($urandom_range(1, 40000)),
                   5'($urandom_range(1, 16)), 16'($urandom_range(0, 300)));
      run_random(PHASE_ITEMS);
      apply_config(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                   16'($urandom_range(0, 65535)), 16'($urandom_range(1, 40000)),
                   5'($urandom_range(1, 16)), 16'($urandom_range(0, 300)));
      run_random(PHASE_ITEMS);
      apply_config(etpm_pkg::RST_REVERSE_PULSE, etpm_pkg::RST_NEUTRAL_PULSE,
                   etpm_pkg::RST_FORWARD_PULSE, etpm_pkg::RST_PWM_FREQ,
                   etpm_pkg::RST_DUTY_RES, etpm_pkg::RST_NEUTRAL_HOLD);
      ms_now = 32'hFFFF_FF00;
      run_random(PHASE_ITEMS);

      drain_block();

      $display("Covered %0d requests over %0d register settings: %0d responses checked,",
               tracker.accepted, tracker.settings, tracker.checked);
      $display("%0d forced-neutral reversals, %0d requests dropped during a hold.",
               tracker.reversals, tracker.dropped);
      if (tracker.mismatches == 0 && tracker.pending_outputs.size() == 0) begin
         $display("esc_throttle_pwm_mapper: match");
      end else begin
         $display("esc_throttle_pwm_mapper: mismatch");
      end
      $finish;
   end

endmodule
